### hdl/pdc_pkg.sv
// Shared types, constants and helpers of the packet deframer with checksum check.
package pdc_pkg;

	localparam int unsigned POS_W     = 17;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam int unsigned HDR_LEN  = 8;
	localparam int unsigned CKS_LEN  = 4;
	localparam int unsigned MIN_PKT  = HDR_LEN + CKS_LEN;
	localparam logic [7:0]  HDR_BYTE = 8'(HDR_LEN);

	// header byte offsets
	localparam logic [POS_W-1:0] OFS_HDR_LEN = 17'd0;
	localparam logic [POS_W-1:0] OFS_CHAN    = 17'd1;
	localparam logic [POS_W-1:0] OFS_LEN_LO  = 17'd2;
	localparam logic [POS_W-1:0] OFS_LEN_HI  = 17'd3;
	localparam logic [POS_W-1:0] OFS_SEQ     = 17'd4;
	localparam logic [POS_W-1:0] OFS_IFACE   = 17'd5;
	localparam logic [POS_W-1:0] OFS_PAD0    = 17'd6;
	localparam logic [POS_W-1:0] OFS_PAD1    = 17'd7;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CMD_CHAN  = 2'd0,
		CFG_RPT_CHAN  = 2'd1,
		CFG_MAX_IFACE = 2'd2,
		CFG_MAX_LEN   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_INCOMPLETE = 4'd1,
		ST_BAD_HEADER = 4'd2,
		ST_CHANNEL    = 4'd3,
		ST_INTERFACE  = 4'd4,
		ST_LENGTH     = 4'd5,
		ST_ALIGNMENT  = 4'd6,
		ST_TRAILING   = 4'd7,
		ST_CHECKSUM   = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		SEG_SUM  = 2'd0,
		SEG_CKS  = 2'd1,
		SEG_NONE = 2'd2
	} seg_t;

	typedef struct packed {
		logic [7:0]  command_channel_id;
		logic [7:0]  report_channel_id;
		logic [7:0]  max_interface;
		logic [15:0] max_body_length;
	} cfg_t;

	typedef struct packed {
		logic align;
		logic len;
		logic pad;
		logic iface;
		logic chan;
		logic hdr;
	} fault_t;

	// one classified byte handed from front to back
	typedef struct packed {
		logic [7:0]       data;
		logic [1:0]       lane;
		seg_t             seg;
		logic             fwd;
		logic             last;
		status_t          status;   // ST_OK here means checksum still to be checked
		logic [7:0]       channel;
		logic [7:0]       seq;
		logic [7:0]       iface;
		logic [15:0]      body_len;
		logic [POS_W-1:0] pkt_len;
	} op_t;

	function automatic status_t fault_status(fault_t f);
		status_t st;
		st = ST_OK;
		if (f.hdr) st = ST_BAD_HEADER;
		else if (f.chan) st = ST_CHANNEL;
		else if (f.iface) st = ST_INTERFACE;
		else if (f.pad) st = ST_BAD_HEADER;
		else if (f.len) st = ST_LENGTH;
		else if (f.align) st = ST_ALIGNMENT;
		return st;
	endfunction

endpackage

### hdl/pdc_if.sv
// Request channel interfaces: packet bytes in, body bytes and status out.
interface pdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface pdc_res_if;
	logic                           valid;
	logic                           ready;
	logic                           result_kind;
	logic [7:0]                     body_byte;
	pdc_pkg::status_t               status;
	logic [7:0]                     channel;
	logic [7:0]                     sequence_res;
	logic [7:0]                     interface_res;
	logic [15:0]                    body_length;
	logic [31:0]                    checksum;
	logic [pdc_pkg::POS_W-1:0]      packet_length;

	modport source(output valid, result_kind, body_byte, status, channel, sequence_res,
		interface_res, body_length, checksum, packet_length, input ready);
	modport sink(input valid, result_kind, body_byte, status, channel, sequence_res,
		interface_res, body_length, checksum, packet_length, output ready);
endinterface

### hdl/pdc_fifo.sv
// Short register queue of classified bytes between front and back.
module pdc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pdc_pkg::op_t    push_op,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output pdc_pkg::op_t    head
);

	pdc_pkg::op_t                  mem_q [pdc_pkg::QDEPTH];
	logic [pdc_pkg::QPTR_W-1:0]    wr_q;
	logic [pdc_pkg::QPTR_W-1:0]    rd_q;
	logic [pdc_pkg::QCNT_W-1:0]    count_q;

	assign full  = (count_q == pdc_pkg::QCNT_W'(pdc_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == pdc_pkg::QPTR_W'(pdc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == pdc_pkg::QPTR_W'(pdc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pdc_pkg::QCNT_W'(pdc_pkg::QDEPTH))
		else $error("queue count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty && !(push && full))
		else $error("queue popped while empty or pushed while full");

endmodule

### hdl/pdc_front.sv
// Front: tracks byte position, captures and checks the header, classifies each byte.
module pdc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  pdc_pkg::cfg_t   cfg,
	pdc_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            push,
	output pdc_pkg::op_t    push_op
);

	logic [pdc_pkg::POS_W-1:0] pos_q;
	logic [7:0]                chan_q;
	logic [7:0]                seq_q;
	logic [7:0]                iface_q;
	logic [15:0]               len_q;
	pdc_pkg::fault_t           flags_q;

	logic [7:0]                chan_nxt;
	logic [7:0]                seq_nxt;
	logic [7:0]                iface_nxt;
	logic [15:0]               len_nxt;
	pdc_pkg::fault_t           flags_nxt;
	logic [pdc_pkg::POS_W-1:0] body_end;
	logic [pdc_pkg::POS_W-1:0] cks_end;
	logic [pdc_pkg::POS_W-1:0] cks_last;
	logic [7:0]                b;
	logic [pdc_pkg::POS_W-1:0] p;
	pdc_pkg::status_t          st;
	pdc_pkg::seg_t             seg;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;
	assign b           = in_ch.data_byte;
	assign p           = pos_q;

	always_comb begin
		chan_nxt  = chan_q;
		seq_nxt   = seq_q;
		iface_nxt = iface_q;
		len_nxt   = len_q;
		flags_nxt = flags_q;
		case (p)
			pdc_pkg::OFS_HDR_LEN: begin
				if (b != pdc_pkg::HDR_BYTE) flags_nxt.hdr = 1'b1;
			end
			pdc_pkg::OFS_CHAN: begin
				chan_nxt = b;
				if (b != cfg.command_channel_id && b != cfg.report_channel_id)
					flags_nxt.chan = 1'b1;
			end
			pdc_pkg::OFS_LEN_LO: begin
				len_nxt = {8'd0, b};
			end
			pdc_pkg::OFS_LEN_HI: begin
				len_nxt = {b, len_q[7:0]};
				if (len_nxt > cfg.max_body_length) flags_nxt.len = 1'b1;
				if (len_nxt[1:0] != 2'd0) flags_nxt.align = 1'b1;
			end
			pdc_pkg::OFS_SEQ: begin
				seq_nxt = b;
			end
			pdc_pkg::OFS_IFACE: begin
				iface_nxt = b;
				if (b > cfg.max_interface) flags_nxt.iface = 1'b1;
			end
			pdc_pkg::OFS_PAD0, pdc_pkg::OFS_PAD1: begin
				if (b != 8'd0) flags_nxt.pad = 1'b1;
			end
			default: ;
		endcase

		// len_nxt is zero before the length bytes, which leaves the header in the sum
		body_end = pdc_pkg::POS_W'(pdc_pkg::HDR_LEN) + {1'b0, len_nxt};
		cks_end  = body_end + pdc_pkg::POS_W'(pdc_pkg::CKS_LEN);
		cks_last = cks_end - 1'b1;

		if (p < body_end) seg = pdc_pkg::SEG_SUM;
		else if (p < cks_end) seg = pdc_pkg::SEG_CKS;
		else seg = pdc_pkg::SEG_NONE;

		if (p < pdc_pkg::POS_W'(pdc_pkg::MIN_PKT - 1)) st = pdc_pkg::ST_INCOMPLETE;
		else if (flags_nxt != '0) st = pdc_pkg::fault_status(flags_nxt);
		else if (p < cks_last) st = pdc_pkg::ST_INCOMPLETE;
		else if (p > cks_last) st = pdc_pkg::ST_TRAILING;
		else st = pdc_pkg::ST_OK;

		push_op.data     = b;
		push_op.lane     = p[1:0];
		push_op.seg      = seg;
		push_op.fwd      = !in_ch.last_byte && p >= pdc_pkg::POS_W'(pdc_pkg::HDR_LEN)
			&& p < body_end && flags_nxt == '0;
		push_op.last     = in_ch.last_byte;
		push_op.status   = st;
		push_op.channel  = chan_q;
		push_op.seq      = seq_q;
		push_op.iface    = iface_q;
		push_op.body_len = len_q;
		push_op.pkt_len  = p + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			chan_q  <= '0;
			seq_q   <= '0;
			iface_q <= '0;
			len_q   <= '0;
			flags_q <= '0;
		end else if (push) begin
			if (in_ch.last_byte) begin
				pos_q   <= '0;
				chan_q  <= '0;
				seq_q   <= '0;
				iface_q <= '0;
				len_q   <= '0;
				flags_q <= '0;
			end else begin
				if (pos_q != pdc_pkg::POS_MAX) pos_q <= pos_q + 1'b1;
				chan_q  <= chan_nxt;
				seq_q   <= seq_nxt;
				iface_q <= iface_nxt;
				len_q   <= len_nxt;
				flags_q <= flags_nxt;
			end
		end
	end

endmodule

### hdl/pdc_back.sv
// Back: word sum and checksum capture, result formation and output register.
module pdc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  pdc_pkg::op_t    head,
	output logic            pop,
	pdc_res_if.source       res_ch
);

	logic [23:0]               partial_q;
	logic [31:0]               sum_q;
	logic [31:0]               recv_q;

	logic                      out_valid_q;
	logic                      kind_q;
	logic [7:0]                body_byte_q;
	pdc_pkg::status_t          status_q;
	logic [7:0]                chan_q;
	logic [7:0]                seq_q;
	logic [7:0]                iface_q;
	logic [15:0]               len_q;
	logic [31:0]               cks_q;
	logic [pdc_pkg::POS_W-1:0] pkt_len_q;

	logic [23:0]               partial_nxt;
	logic [31:0]               sum_nxt;
	logic [31:0]               recv_nxt;
	pdc_pkg::status_t          fin_status;
	logic                      ok;

	assign pop = !q_empty && (!out_valid_q || res_ch.ready);

	always_comb begin
		partial_nxt = partial_q;
		sum_nxt     = sum_q;
		recv_nxt    = recv_q;
		case (head.seg)
			pdc_pkg::SEG_SUM: begin
				if (head.lane == 2'd3) begin
					sum_nxt     = sum_q + {head.data, partial_q};
					partial_nxt = '0;
				end else begin
					partial_nxt = partial_q | ({16'd0, head.data} << {head.lane, 3'd0});
				end
			end
			pdc_pkg::SEG_CKS: recv_nxt = {head.data, recv_q[31:8]};
			default: ;
		endcase

		// a pending ok always ends on a checksum byte, so the sum is already final
		fin_status = head.status;
		if (head.status == pdc_pkg::ST_OK && recv_nxt != ~sum_q)
			fin_status = pdc_pkg::ST_CHECKSUM;
		ok = (fin_status == pdc_pkg::ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			sum_q       <= '0;
			recv_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					partial_q <= '0;
					sum_q     <= '0;
					recv_q    <= '0;
				end else begin
					partial_q <= partial_nxt;
					sum_q     <= sum_nxt;
					recv_q    <= recv_nxt;
				end
				out_valid_q <= head.last || head.fwd;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.last || head.fwd)) begin
			kind_q      <= head.last;
			body_byte_q <= head.last ? 8'd0 : head.data;
			status_q    <= head.last ? fin_status : pdc_pkg::ST_OK;
			chan_q      <= (head.last && ok) ? head.channel : 8'd0;
			seq_q       <= (head.last && ok) ? head.seq : 8'd0;
			iface_q     <= (head.last && ok) ? head.iface : 8'd0;
			len_q       <= (head.last && ok) ? head.body_len : 16'd0;
			cks_q       <= (head.last && ok) ? recv_nxt : 32'd0;
			pkt_len_q   <= (head.last && ok) ? head.pkt_len : '0;
		end
	end

	assign res_ch.valid         = out_valid_q;
	assign res_ch.result_kind   = kind_q;
	assign res_ch.body_byte     = body_byte_q;
	assign res_ch.status        = status_q;
	assign res_ch.channel       = chan_q;
	assign res_ch.sequence_res  = seq_q;
	assign res_ch.interface_res = iface_q;
	assign res_ch.body_length   = len_q;
	assign res_ch.checksum      = cks_q;
	assign res_ch.packet_length = pkt_len_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q && status_q != pdc_pkg::ST_OK |->
		chan_q == 8'd0 && len_q == 16'd0 && cks_q == 32'd0 && pkt_len_q == '0)
		else $error("failed status carries packet fields");

	a_body_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !kind_q |-> status_q == pdc_pkg::ST_OK && pkt_len_q == '0)
		else $error("body result carries status fields");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q && status_q == pdc_pkg::ST_OK |->
		pkt_len_q == pdc_pkg::POS_W'(pdc_pkg::MIN_PKT) + {1'b0, len_q})
		else $error("ok status with inconsistent packet length");

endmodule

### hdl/packet_deframe_checksum_check.sv
// Top level of the packet deframer with checksum check: config registers and the two halves.
//
// in_ch carries packet bytes, one per request, last_byte set on the final byte.
// A packet is an 8-byte header (length byte 8, channel, little-endian body length,
// sequence, interface, two zero bytes), the body and a 32-bit little-endian checksum.
// res_ch returns one request per body byte (result_kind 0) while the header is clean,
// and one status request (result_kind 1) at each last byte; packet fields are zero
// unless the status is ok. A last byte inside the body gives only the status.
// The cfg port writes command/report channel ids, the interface limit and the body
// length limit; write it only while no packet is in flight (the block does not enforce this).
// Throughput: one byte per cycle while res_ch is ready. Each byte passes the queue write,
// then the output register, on its way to a result.
// The front (position, header capture and checks) feeds a four-entry queue; the back
// (word sum, checksum capture, status) drains it into the output register.
// When res_ch stalls, the queue absorbs up to four bytes before in_ch.ready drops.
// Reset clears the packet state and queue and restores the register defaults;
// no setup pass is needed.
module packet_deframe_checksum_check (
	input  logic                               clk,
	input  logic                               arst_n,
	pdc_in_if.sink                             in_ch,
	pdc_res_if.source                          res_ch,
	input  logic                               cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdc_pkg::CFG_W-1:0]          cfg_wdata
);

	pdc_pkg::cfg_t cfg_q;
	pdc_pkg::op_t  push_op;
	pdc_pkg::op_t  head;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_channel_id <= 8'd17;
			cfg_q.report_channel_id  <= 8'd18;
			cfg_q.max_interface      <= 8'd255;
			cfg_q.max_body_length    <= 16'd65532;
		end else if (cfg_we) begin
			unique case (pdc_pkg::cfg_idx_t'(cfg_index))
				pdc_pkg::CFG_CMD_CHAN:  cfg_q.command_channel_id <= cfg_wdata[7:0];
				pdc_pkg::CFG_RPT_CHAN:  cfg_q.report_channel_id  <= cfg_wdata[7:0];
				pdc_pkg::CFG_MAX_IFACE: cfg_q.max_interface      <= cfg_wdata[7:0];
				pdc_pkg::CFG_MAX_LEN:   cfg_q.max_body_length    <= cfg_wdata[15:0];
			endcase
		end
	end

	pdc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.q_full  (q_full),
		.push    (push),
		.push_op (push_op)
	);

	pdc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head    (head)
	);

	pdc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.res_ch  (res_ch)
	);

endmodule
